// ----- src/signed_int_to_decimal_chars_macros.svh -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_chars assertion macros
// concurrent assertion forms for s2d_ser, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_CHARS_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_CHARS_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define S2D_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define S2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/s2d_pkg.sv -----
// ----------------------------------------------------------------------------
// s2d_pkg
// shared types and constants of the integer to decimal text converter
// ----------------------------------------------------------------------------
package s2d_pkg;

    localparam int VALUE_W   = 32;
    localparam int N_DIG     = 10;
    localparam int DIGIT_W   = 4;
    localparam int BCD_W     = N_DIG * DIGIT_W;
    localparam int CHAR_W    = 6;
    localparam int IDX_W     = 4;
    localparam int STEP_BITS = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef logic [N_DIG-1:0][DIGIT_W-1:0] t_digits;

    // one request in flight through the conversion stages
    typedef struct packed {
        logic               neg;
        t_digits            bcd;
        logic [VALUE_W-1:0] bin;
    } t_dab;

endpackage

// ----- src/s2d_mag.sv -----
// ----------------------------------------------------------------------------
// s2d_mag
// input stage: sign split and magnitude of the two's complement value
// ----------------------------------------------------------------------------
module s2d_mag
    import s2d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output t_dab               o_data
);

    logic r_valid;
    t_dab r_data;
    t_dab n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // unsigned negate keeps the most negative value exact
    always_comb begin
        n_data.neg = i_value[VALUE_W-1];
        n_data.bcd = '0;
        n_data.bin = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- src/s2d_dabble.sv -----
// ----------------------------------------------------------------------------
// s2d_dabble
// one pipeline stage of binary to bcd conversion, several bits per stage
// ----------------------------------------------------------------------------
module s2d_dabble
    import s2d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_dab i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_dab o_data
);

    logic r_valid;
    t_dab r_data;
    t_dab n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // shift-add-3: correct digits of five or more, then shift one bit in
    always_comb begin
        n_data = i_data;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < N_DIG; d++) begin
                if (n_data.bcd[d] >= 4'd5) begin
                    n_data.bcd[d] = n_data.bcd[d] + 4'd3;
                end
            end
            {n_data.bcd, n_data.bin} = {n_data.bcd, n_data.bin} << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- src/s2d_ser.sv -----
// ----------------------------------------------------------------------------
// s2d_ser
// character serializer: sign, then digits from the leading nonzero one
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_chars_macros.svh"

module s2d_ser
    import s2d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_dab              i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_final_char
);

    logic             r_busy;
    logic             r_sign;
    logic [IDX_W-1:0] r_idx;
    t_digits          r_digits;
    logic [IDX_W-1:0] n_idx;
    logic             load;

    // position of the leading nonzero digit, zero gives one digit
    always_comb begin
        n_idx = '0;
        for (int d = 0; d < N_DIG; d++) begin
            if (i_data.bcd[d] != '0) begin
                n_idx = IDX_W'(d);
            end
        end
    end

    assign o_valid      = r_busy;
    assign o_final_char = !r_sign && (r_idx == '0);
    assign o_character  = r_sign ? CHAR_MINUS
                                 : CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, r_digits[r_idx]};
    assign o_ready      = !r_busy || (i_ready && o_final_char);
    assign load         = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_sign <= i_data.neg;
            r_idx  <= n_idx;
        end else if (r_busy && i_ready) begin
            if (o_final_char) begin
                r_busy <= 1'b0;
            end else if (r_sign) begin
                r_sign <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
        if (load) begin
            r_digits <= i_data.bcd;
        end
    end

    `S2D_ASSERT_SAME(a_sign_not_final, r_busy && r_sign, !o_final_char, "minus sign flagged final")
    `S2D_ASSERT_SAME(a_idx_range, r_busy, r_idx <= IDX_W'(N_DIG - 1), "digit index out of range")
    `S2D_ASSERT_NEXT(a_load_busy, i_valid && o_ready, r_busy, "loaded request not held")
    `S2D_ASSERT_NEXT(a_drain_idle, r_busy && i_ready && o_final_char && !i_valid, !r_busy, "busy after final char")

endmodule

// ----- src/signed_int_to_decimal_chars.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_chars
// 32-bit two's complement integer to decimal ascii, one char per ready cycle
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid / o_ready carries one request, i_value (32 bits,
//   signed). output channel o_valid / i_ready carries one character per
//   transfer: o_character (ascii '-' or '0'..'9') and o_final_char, set on
//   the last character of a number. a negative value starts with '-', zero
//   gives a single '0', no leading zeros are sent.
// path: the magnitude stage loads at the accepting edge, then the four bcd
//   stages and the serializer load in turn; the first character of a
//   request is offered once the serializer has loaded it.
// flow: a request gives 1 to 11 characters, one per transfer. the serializer
//   takes the next request only in the same cycle as the final character of
//   the current one leaves, so a waiting request follows with no gap.
// stall: while i_ready is low the current character holds; the pipeline in
//   front keeps taking requests until all five stages are full, then o_ready
//   drops. nothing is lost or repeated.
// reset: i_rst_n low (synchronous) empties every stage; no other state.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_chars
    import s2d_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [CHAR_W-1:0]         o_character,
    output logic                      o_final_char
);

    localparam int N_STAGE = VALUE_W / STEP_BITS;

    // stage links: index 0 is the magnitude stage output
    logic [N_STAGE:0] link_valid;
    logic [N_STAGE:0] link_ready;
    t_dab             link_data [N_STAGE+1];

    // sign split and magnitude
    s2d_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_valid (link_valid[0]),
        .i_ready (link_ready[0]),
        .o_data  (link_data[0])
    );

    // binary to bcd, a byte of the magnitude per stage
    for (genvar g = 0; g < N_STAGE; g++) begin : g_dab
        s2d_dabble u_dab (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[g]),
            .o_ready (link_ready[g]),
            .i_data  (link_data[g]),
            .o_valid (link_valid[g+1]),
            .i_ready (link_ready[g+1]),
            .o_data  (link_data[g+1])
        );
    end

    // characters out, most significant first
    s2d_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (link_valid[N_STAGE]),
        .o_ready      (link_ready[N_STAGE]),
        .i_data       (link_data[N_STAGE]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_character  (o_character),
        .o_final_char (o_final_char)
    );

endmodule
